### hdl/lvs_pkg.sv
// shared types and constants for the longest valley subsequence core
package lvs_pkg;

    localparam int SAMPLE_W = 30;
    localparam int VALLEY_W = 13;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [VALLEY_W-1:0] t_valley;

    typedef struct packed {
        logic start;
        logic clear;
    } t_tails_ctl;

endpackage

### hdl/lvs_if.sv
// request channel interfaces for sample input and valley result
interface lvs_in_if;
    import lvs_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_value;
    logic    end_of_sequence;

    modport source (output valid, output sample_value, output end_of_sequence, input ready);
    modport sink   (input valid, input sample_value, input end_of_sequence, output ready);
endinterface

interface lvs_out_if;
    import lvs_pkg::*;

    logic    valid;
    logic    ready;
    t_valley longest_valley;
    logic    overflowed;

    modport source (output valid, output longest_valley, output overflowed, input ready);
    modport sink   (input valid, input longest_valley, input overflowed, output ready);
endinterface

### hdl/lvs_store.sv
// sequence store: sample values and decreasing lengths per position
module lvs_store #(
    parameter int MAX_LEN = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(MAX_LEN)-1:0]     i_wr_addr,
    input  lvs_pkg::t_sample               i_wr_value,
    input  logic [$clog2(MAX_LEN+1)-1:0]   i_wr_len,
    input  logic [$clog2(MAX_LEN)-1:0]     i_rd_addr,
    output lvs_pkg::t_sample               o_rd_value,
    output logic [$clog2(MAX_LEN+1)-1:0]   o_rd_len
);
    import lvs_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);

    t_sample         r_values [MAX_LEN];
    logic [CW-1:0]   r_lens   [MAX_LEN];
    t_sample         r_rd_value;
    logic [CW-1:0]   r_rd_len;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_values[i_wr_addr] <= i_wr_value;
            r_lens[i_wr_addr]   <= i_wr_len;
        end
        r_rd_value <= r_values[i_rd_addr];
        r_rd_len   <= r_lens[i_rd_addr];
    end

    assign o_rd_value = r_rd_value;
    assign o_rd_len   = r_rd_len;

endmodule

### hdl/lvs_tails.sv
// tails table with bitwise search and insert, one compare per cycle
module lvs_tails #(
    parameter int MAX_LEN = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lvs_pkg::t_tails_ctl            i_ctl,
    input  lvs_pkg::t_sample               i_value,
    output logic                           o_done,
    output logic [$clog2(MAX_LEN+1)-1:0]   o_len
);
    import lvs_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);

    t_sample         r_tails [MAX_LEN];
    t_sample         r_rd;
    logic            r_busy;
    logic            r_chk;
    logic            r_done;
    logic            r_cand_ok;
    logic [CW-1:0]   r_j;
    logic [CW-1:0]   r_mask;
    logic [CW-1:0]   r_cand;
    logic [CW-1:0]   r_tlen;
    logic [CW-1:0]   r_len;

    logic            hit;
    logic            last_step;
    logic            full;
    logic            wr_en;
    logic [CW-1:0]   j_eff;
    logic [CW-1:0]   cand;
    logic [CW-1:0]   cand_m1;
    logic [CW-1:0]   new_len;
    logic [CW-1:0]   wr_pos;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;

    always_comb begin
        hit       = r_chk && r_cand_ok && (r_rd > i_value);
        j_eff     = hit ? r_cand : r_j;
        last_step = r_chk && (r_mask == '0);
        cand      = j_eff | r_mask;
        cand_m1   = cand - CW'(1);
        rd_addr   = cand_m1[AW-1:0];
        full      = (j_eff == CW'(MAX_LEN));
        new_len   = full ? CW'(MAX_LEN) : j_eff + CW'(1);
        wr_pos    = full ? CW'(MAX_LEN - 1) : j_eff;
        wr_addr   = wr_pos[AW-1:0];
        wr_en     = r_busy && last_step;
    end

    // table memory, no reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tails[wr_addr] <= i_value;
        end
        r_rd <= r_tails[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_chk     <= 1'b0;
            r_done    <= 1'b0;
            r_tlen    <= '0;
            r_j       <= '0;
            r_mask    <= '0;
            r_cand    <= '0;
            r_cand_ok <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.clear) begin
                r_tlen <= '0;
            end
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_chk  <= 1'b0;
                r_j    <= '0;
                r_mask <= {1'b1, {(CW-1){1'b0}}};
            end else if (r_busy) begin
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_len  <= new_len;
                    if (new_len > r_tlen) begin
                        r_tlen <= new_len;
                    end
                end else begin
                    r_j       <= j_eff;
                    r_cand    <= cand;
                    r_cand_ok <= (cand <= r_tlen);
                    r_mask    <= r_mask >> 1;
                    r_chk     <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_len  = r_len;

endmodule

### hdl/longest_valley_subsequence_core.sv
// longest valley subsequence core: sequencer, sequence store and tails search
// each stored item runs a tails search that reads one table entry and compares
// once per cycle; no new item is accepted until that search completes
// the marked last item adds a backward tails search per stored item and then a registered output
// a dropped item over capacity is accepted without a tails search
// synchronous reset clears counters and flags, memories keep their contents
module longest_valley_subsequence_core #(
    parameter int MAX_LEN = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lvs_in_if.sink     i_in,
    lvs_out_if.source  o_out
);
    import lvs_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int SW = $clog2(2 * MAX_LEN + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_BLOAD,
        S_OUT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    t_sample         r_v;
    logic            r_last;
    logic            r_back;
    logic            r_ovf;
    logic [SW-1:0]   r_best;
    logic            r_ovalid;
    t_valley         r_oval;
    logic            r_oovf;

    logic            accept;
    logic            have_room;
    logic            t_done;
    logic [CW-1:0]   t_len;
    logic [CW-1:0]   st_len;
    t_sample         st_value;
    t_sample         s_value;
    logic [CW-1:0]   cnt_m1;
    logic [SW-1:0]   sum;
    logic [SW-1:0]   best_m1;
    t_tails_ctl      t_ctl;

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        accept      = i_in.valid && i_in.ready;
        have_room   = (r_count != CW'(MAX_LEN));
        cnt_m1      = r_count - CW'(1);
        s_value     = r_back ? st_value : r_v;
        sum         = SW'(st_len) + SW'(t_len);
        best_m1     = r_best - SW'(1);
        t_ctl.start = (accept && have_room) || (r_state == S_BLOAD);
        t_ctl.clear = (accept && !have_room && i_in.end_of_sequence)
                    || ((r_state == S_SRCH) && t_done && !r_back && r_last)
                    || (r_state == S_OUT);
    end

    lvs_store #(.MAX_LEN(MAX_LEN)) u_store (
        .i_clk      (i_clk),
        .i_wr_en    ((r_state == S_SRCH) && t_done && !r_back),
        .i_wr_addr  (r_count[AW-1:0]),
        .i_wr_value (r_v),
        .i_wr_len   (t_len),
        .i_rd_addr  (cnt_m1[AW-1:0]),
        .o_rd_value (st_value),
        .o_rd_len   (st_len)
    );

    lvs_tails #(.MAX_LEN(MAX_LEN)) u_tails (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (t_ctl),
        .i_value (s_value),
        .o_done  (t_done),
        .o_len   (t_len)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_last   <= 1'b0;
            r_back   <= 1'b0;
            r_ovf    <= 1'b0;
            r_best   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_v    <= i_in.sample_value;
                        r_last <= i_in.end_of_sequence;
                        if (have_room) begin
                            r_back  <= 1'b0;
                            r_state <= S_SRCH;
                        end else begin
                            r_ovf <= 1'b1;
                            if (i_in.end_of_sequence) begin
                                r_best  <= '0;
                                r_back  <= 1'b1;
                                r_state <= S_BLOAD;
                            end
                        end
                    end
                end
                S_SRCH: begin
                    if (t_done) begin
                        if (!r_back) begin
                            r_count <= r_count + CW'(1);
                            if (r_last) begin
                                r_best  <= '0;
                                r_back  <= 1'b1;
                                r_state <= S_BLOAD;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            if (sum > r_best) begin
                                r_best <= sum;
                            end
                            r_count <= cnt_m1;
                            r_state <= (cnt_m1 == '0) ? S_OUT : S_BLOAD;
                        end
                    end
                end
                S_BLOAD: begin
                    r_state <= S_SRCH;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= VALLEY_W'(best_m1);
                        r_oovf   <= r_ovf;
                        r_ovf    <= 1'b0;
                        r_best   <= '0;
                        r_back   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.longest_valley = r_oval;
    assign o_out.overflowed     = r_oovf;

endmodule
